@@ hw/rtl/spg_pkg.sv @@
// spg_pkg: shared types and constants for the stepper pulse generator
// holds the register map, configuration struct and result struct
// no dependencies
`timescale 1ns / 1ps

package spg_pkg;

   // register map, one 32-bit register every four bytes
   localparam int unsigned SPG_ADDR_BITS = 5;
   localparam int unsigned SPG_DATA_BITS = 32;

   typedef enum logic [2:0] {
      REG_TOGGLE_TICKS     = 3'd0,
      REG_CHECK_INTERVAL   = 3'd1,
      REG_OWED_PER_STEP    = 3'd2,
      REG_CREDIT_PER_COUNT = 3'd3,
      REG_DESYNC_LIMIT     = 3'd4
   } spg_reg_type;

   // reset values of the registers
   localparam logic [15:0] RST_TOGGLE_TICKS     = 16'd10;
   localparam logic [15:0] RST_CHECK_INTERVAL   = 16'd64;
   localparam logic [7:0]  RST_OWED_PER_STEP    = 8'd5;
   localparam logic [7:0]  RST_CREDIT_PER_COUNT = 8'd2;
   localparam logic [31:0] RST_DESYNC_LIMIT     = 32'd1000;

   // request and response payload widths
   localparam int unsigned REQ_DATA_BITS = 48;
   localparam int unsigned RSP_DATA_BITS = 88;

   // input command codes
   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_START = 1'b1;

   typedef struct packed {
      logic [15:0] toggle_ticks;
      logic [15:0] check_interval;
      logic [7:0]  owed_per_step;
      logic [7:0]  credit_per_count;
      logic [31:0] desync_limit;
   } spg_cfg_type;

   typedef struct packed {
      logic [15:0] peak_move;
      logic [31:0] worst_desync;
      logic [31:0] desync_error;
      logic        stalled;
      logic        move_done;
      logic        motor_enable;
      logic        step_level;
   } spg_result_type;

endpackage

@@ hw/rtl/spg_csr.sv @@
// spg_csr: configuration registers behind the APB-style port
// depends on spg_pkg for the register map and the configuration struct
`timescale 1ns / 1ps

module spg_csr import spg_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [SPG_ADDR_BITS-1:0] csr_paddr,
   input  logic [SPG_DATA_BITS-1:0] csr_pwdata,
   output logic [SPG_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   output spg_cfg_type              cfg
);

   spg_cfg_type cfg_ff;
   spg_cfg_type cfg_in;
   spg_reg_type reg_sel;
   logic        wr_en;

   assign reg_sel    = spg_reg_type'(csr_paddr[4:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // register write decode, unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_TOGGLE_TICKS:     cfg_in.toggle_ticks     = csr_pwdata[15:0];
            REG_CHECK_INTERVAL:   cfg_in.check_interval   = csr_pwdata[15:0];
            REG_OWED_PER_STEP:    cfg_in.owed_per_step    = csr_pwdata[7:0];
            REG_CREDIT_PER_COUNT: cfg_in.credit_per_count = csr_pwdata[7:0];
            REG_DESYNC_LIMIT:     cfg_in.desync_limit     = csr_pwdata;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.toggle_ticks     <= RST_TOGGLE_TICKS;
         cfg_ff.check_interval   <= RST_CHECK_INTERVAL;
         cfg_ff.owed_per_step    <= RST_OWED_PER_STEP;
         cfg_ff.credit_per_count <= RST_CREDIT_PER_COUNT;
         cfg_ff.desync_limit     <= RST_DESYNC_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back mux
   always_comb begin
      case (reg_sel)
         REG_TOGGLE_TICKS:     csr_prdata = 32'(cfg_ff.toggle_ticks);
         REG_CHECK_INTERVAL:   csr_prdata = 32'(cfg_ff.check_interval);
         REG_OWED_PER_STEP:    csr_prdata = 32'(cfg_ff.owed_per_step);
         REG_CREDIT_PER_COUNT: csr_prdata = 32'(cfg_ff.credit_per_count);
         REG_DESYNC_LIMIT:     csr_prdata = cfg_ff.desync_limit;
         default:              csr_prdata = '0;
      endcase
   end

endmodule

@@ hw/rtl/spg_axis.sv @@
// spg_axis: axis state and the combinational update for one request
// step timing, move completion and encoder desync check; depends on spg_pkg
`timescale 1ns / 1ps

module spg_axis import spg_pkg::*; #(
   parameter int unsigned ENCODER_BITS = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  logic           cmd,
   input  logic [31:0]    target,
   input  logic [15:0]    enc,
   input  spg_cfg_type    cfg,
   output spg_result_type result
);

   localparam int unsigned EB = ENCODER_BITS;

   logic          moving_ff, moving_in;
   logic [15:0]   tick_count_ff, tick_count_in;
   logic          pin_level_ff, pin_level_in;
   logic [31:0]   steps_taken_ff, steps_taken_in;
   logic [31:0]   target_hold_ff, target_hold_in;
   logic [15:0]   check_countdown_ff, check_countdown_in;
   logic [EB-1:0] last_sample_ff, last_sample_in;
   logic [15:0]   peak_hold_ff, peak_hold_in;
   logic [31:0]   commanded_total_ff, commanded_total_in;
   logic [31:0]   travel_total_ff, travel_total_in;
   logic [31:0]   error_now_ff, error_now_in;
   logic [31:0]   error_worst_ff, error_worst_in;
   logic          stall_flag_ff, stall_flag_in;
   logic          done;

   // encoder sample at the configured width
   logic [EB-1:0]      enc_s;
   logic [EB-1:0]      diff;
   logic [31:0]        delta;
   logic [EB-1:0]      moved;
   logic [15:0]        peak_chk;
   logic [31:0]        cmd_total_chk;
   logic [31:0]        travel_chk;
   logic [31:0]        travelled;
   logic [31:0]        owed;
   logic [31:0]        delivered;
   logic [32:0]        err_diff;
   logic [31:0]        err_chk;
   logic [31:0]        worst_chk;
   logic               stall_chk;

   // step timing helpers
   logic [15:0] tick_inc;
   logic [31:0] steps_inc;
   logic [15:0] cd_dec;

   assign enc_s   = EB'(enc);
   assign diff    = enc_s - last_sample_ff;
   assign delta   = 32'($signed(diff));
   assign moved   = diff[EB-1] ? (~diff + 1'b1) : diff;

   // peak absolute delta
   assign peak_chk = (33'(moved) > 33'(peak_hold_ff)) ? 16'(moved) : peak_hold_ff;

   // totals and floored error, all wrapping at 32 bits
   assign cmd_total_chk  = commanded_total_ff + 32'(cfg.check_interval);
   assign travel_chk     = travel_total_ff + delta;
   assign travelled      = travel_chk[31] ? (32'd0 - travel_chk) : travel_chk;
   assign owed           = cmd_total_chk * 32'(cfg.owed_per_step);
   assign delivered      = travelled * 32'(cfg.credit_per_count);
   assign err_diff       = {1'b0, owed} - {1'b0, delivered};
   assign err_chk        = err_diff[32] ? 32'd0 : err_diff[31:0];
   assign worst_chk      = (err_chk > error_worst_ff) ? err_chk : error_worst_ff;
   assign stall_chk      = (peak_chk != 16'd0) && (err_chk >= cfg.desync_limit);

   assign tick_inc  = tick_count_ff + 16'd1;
   assign steps_inc = steps_taken_ff + 32'd1;
   assign cd_dec    = check_countdown_ff - 16'd1;

   // next state for the request being retired
   always_comb begin
      moving_in          = moving_ff;
      tick_count_in      = tick_count_ff;
      pin_level_in       = pin_level_ff;
      steps_taken_in     = steps_taken_ff;
      target_hold_in     = target_hold_ff;
      check_countdown_in = check_countdown_ff;
      last_sample_in     = last_sample_ff;
      peak_hold_in       = peak_hold_ff;
      commanded_total_in = commanded_total_ff;
      travel_total_in    = travel_total_ff;
      error_now_in       = error_now_ff;
      error_worst_in     = error_worst_ff;
      stall_flag_in      = stall_flag_ff;
      done               = 1'b0;
      if (cmd == CMD_START && !moving_ff) begin
         // start of a move clears everything and takes the encoder baseline
         moving_in          = 1'b1;
         tick_count_in      = '0;
         pin_level_in       = 1'b0;
         steps_taken_in     = '0;
         target_hold_in     = target;
         check_countdown_in = cfg.check_interval;
         last_sample_in     = enc_s;
         peak_hold_in       = '0;
         commanded_total_in = '0;
         travel_total_in    = '0;
         error_now_in       = '0;
         error_worst_in     = '0;
         stall_flag_in      = 1'b0;
      end else if (moving_ff) begin
         if (tick_inc >= cfg.toggle_ticks) begin
            tick_count_in = '0;
            if (!pin_level_ff) begin
               pin_level_in = 1'b1;
            end else begin
               // falling edge counts a microstep
               pin_level_in   = 1'b0;
               steps_taken_in = steps_inc;
               if (steps_inc >= target_hold_ff) begin
                  moving_in = 1'b0;
                  done      = 1'b1;
               end else if (check_countdown_ff != 16'd0) begin
                  check_countdown_in = cd_dec;
                  if (cd_dec == 16'd0) begin
                     // encoder check
                     check_countdown_in = cfg.check_interval;
                     last_sample_in     = enc_s;
                     peak_hold_in       = peak_chk;
                     commanded_total_in = cmd_total_chk;
                     travel_total_in    = travel_chk;
                     error_now_in       = err_chk;
                     error_worst_in     = worst_chk;
                     if (stall_chk) begin
                        moving_in     = 1'b0;
                        stall_flag_in = 1'b1;
                     end
                  end
               end
            end
         end else begin
            tick_count_in = tick_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         moving_ff          <= 1'b0;
         tick_count_ff      <= '0;
         pin_level_ff       <= 1'b0;
         steps_taken_ff     <= '0;
         target_hold_ff     <= '0;
         check_countdown_ff <= '0;
         last_sample_ff     <= '0;
         peak_hold_ff       <= '0;
         commanded_total_ff <= '0;
         travel_total_ff    <= '0;
         error_now_ff       <= '0;
         error_worst_ff     <= '0;
         stall_flag_ff      <= 1'b0;
      end else if (advance) begin
         moving_ff          <= moving_in;
         tick_count_ff      <= tick_count_in;
         pin_level_ff       <= pin_level_in;
         steps_taken_ff     <= steps_taken_in;
         target_hold_ff     <= target_hold_in;
         check_countdown_ff <= check_countdown_in;
         last_sample_ff     <= last_sample_in;
         peak_hold_ff       <= peak_hold_in;
         commanded_total_ff <= commanded_total_in;
         travel_total_ff    <= travel_total_in;
         error_now_ff       <= error_now_in;
         error_worst_ff     <= error_worst_in;
         stall_flag_ff      <= stall_flag_in;
      end
   end

   // result reflects the state after this request
   assign result.step_level   = pin_level_in;
   assign result.motor_enable = moving_in;
   assign result.move_done    = done;
   assign result.stalled      = stall_flag_in;
   assign result.desync_error = error_now_in;
   assign result.worst_desync = error_worst_in;
   assign result.peak_move    = peak_hold_in;

endmodule

@@ hw/rtl/stepper_pulse_gen_stall_detect.sv @@
// Step pulse generator for one stepper axis with encoder stall detection. Each request is a
// timer tick or a start command and yields exactly one response carrying the step pin level,
// driver enable, done pulse, sticky stall flag and the desync figures. The block takes one
// request per clock while the response side is not stalled; a request passes through an input
// register, the axis state update and a result register, which holds the response until it is
// taken. The axis state update is combinational; its longest path is the
// encoder check (wrapped delta, running totals, two 32x8 multiplies, a subtract and compares).
// No clearing pass after reset. Configuration sits in five 32-bit registers at byte offsets 0
// to 16. ENCODER_BITS sets the width at which encoder deltas wrap (8 to 32).
// Depends on spg_pkg, spg_csr and spg_axis.
`timescale 1ns / 1ps

module stepper_pulse_gen_stall_detect import spg_pkg::*; #(
   parameter int unsigned ENCODER_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,  // target_count[31:0], encoder_position[47:32]
   input  logic                     req_tuser,  // command
   // response channel
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // step_level[0], motor_enable[1], move_done[2], stalled[3], desync_error[35:4],
   // worst_desync[67:36], peak_move[83:68], zero fill[87:84]
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   // configuration port
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [SPG_ADDR_BITS-1:0] csr_paddr,
   input  logic [SPG_DATA_BITS-1:0] csr_pwdata,
   output logic [SPG_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   spg_cfg_type    cfg;
   spg_result_type result;

   logic        s1_valid_ff, s1_valid_in;
   logic        cmd_ff;
   logic [31:0] target_ff;
   logic [15:0] enc_ff;
   logic        s2_valid_ff, s2_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff;
   logic        req_fire;
   logic        advance;

   spg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   spg_axis #(
      .ENCODER_BITS (ENCODER_BITS)
   ) u_axis (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .cmd     (cmd_ff),
      .target  (target_ff),
      .enc     (enc_ff),
      .cfg     (cfg),
      .result  (result)
   );

   // two-register flow: input register, then result register
   assign advance     = s1_valid_ff & (~s2_valid_ff | rsp_tready);
   assign req_tready  = ~s1_valid_ff | advance;
   assign req_fire    = req_tvalid & req_tready;
   assign s1_valid_in = req_fire | (s1_valid_ff & ~advance);
   assign s2_valid_in = advance | (s2_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // request payload capture
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff    <= req_tuser;
         target_ff <= req_tdata[31:0];
         enc_ff    <= req_tdata[47:32];
      end
   end

   // response payload capture
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= RSP_DATA_BITS'(result);
      end
   end

   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ hw/rtl/spg_checker.sv @@
// spg_checker: port-level checks for the stepper pulse generator
// bound to stepper_pulse_gen_stall_detect; depends on spg_pkg
`timescale 1ns / 1ps

module spg_checker import spg_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tready,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // a finished or stalled move never leaves the driver enabled
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[2] || rsp_tdata[3]) |-> !rsp_tdata[1])
      else $error("driver enabled after done or stall");

   // done and stall never come together
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[2] && rsp_tdata[3]))
      else $error("done and stalled both set");

   // worst desync covers the current desync
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[67:36] >= rsp_tdata[35:4])
      else $error("worst desync below current desync");

   // a request can always be taken while the response side is empty
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request blocked with empty response side");

endmodule

bind stepper_pulse_gen_stall_detect spg_checker u_spg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ dv/stepper_pulse_gen_stall_detect_tb.sv @@
// stepper_pulse_gen_stall_detect_tb: self-checking bench for the stepper step generator
// drives tick and start requests, predicts every response from a local axis model and
// compares field by field; depends on spg_pkg and stepper_pulse_gen_stall_detect
`timescale 1ns / 1ps

module stepper_pulse_gen_stall_detect_tb import spg_pkg::*; ();

   // one request as queued for the driver
   typedef struct {
      logic        cmd;
      logic [31:0] target;
      logic [15:0] enc;
   } axis_req_type;

   // axis state as the predictor tracks it
   typedef struct {
      logic        moving;
      logic [15:0] tick_count;
      logic        pin_level;
      logic [31:0] steps_taken;
      logic [31:0] target_hold;
      logic [15:0] check_countdown;
      logic [15:0] last_sample;
      logic [15:0] peak_hold;
      logic [31:0] commanded_total;
      logic [31:0] travel_total;
      logic [31:0] error_now;
      logic [31:0] error_worst;
      logic        stall_flag;
   } axis_state_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic                     req_tuser = CMD_TICK;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [SPG_ADDR_BITS-1:0] csr_paddr = '0;
   logic [SPG_DATA_BITS-1:0] csr_pwdata = '0;
   logic [SPG_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   // live register copy, starts at the reset values
   spg_cfg_type cfg_live = '{toggle_ticks: RST_TOGGLE_TICKS,
                             check_interval: RST_CHECK_INTERVAL,
                             owed_per_step: RST_OWED_PER_STEP,
                             credit_per_count: RST_CREDIT_PER_COUNT,
                             desync_limit: RST_DESYNC_LIMIT};

   axis_state_type axis_now = '{default: '0};   // follows accepted requests
   axis_state_type axis_plan = '{default: '0};  // follows queued requests, steers stimulus

   axis_req_type   pending_requests[$];
   spg_result_type status_due[$];

   int unsigned requests_queued = 0;
   int unsigned req_sent = 0;
   int unsigned req_accepted = 0;
   int unsigned mismatches = 0;
   int unsigned moves_done = 0;
   int unsigned stall_stops = 0;
   int unsigned settings_used = 0;
   int unsigned sender_idle_pct = 25;
   int unsigned receiver_idle_pct = 51;

   stepper_pulse_gen_stall_detect #(
      .ENCODER_BITS(16)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // axis update for one request, returns the status it produces
   function automatic spg_result_type advance_axis(inout axis_state_type s,
                                                   input spg_cfg_type c,
                                                   input logic cmd, input logic [31:0] target,
                                                   input logic [15:0] enc);
      spg_result_type r;
      logic [15:0]    diff;
      logic [31:0]    delta;
      logic [31:0]    moved;
      logic [31:0]    travelled;
      logic [31:0]    owed;
      logic [31:0]    delivered;
      r = '0;
      if (cmd == CMD_START && !s.moving) begin
         s = '{default: '0};
         s.moving = 1'b1;
         s.target_hold = target;
         s.check_countdown = c.check_interval;
         s.last_sample = enc;
      end else if (s.moving) begin
         s.tick_count = s.tick_count + 16'd1;
         if (s.tick_count >= c.toggle_ticks) begin
            s.tick_count = '0;
            if (!s.pin_level) begin
               s.pin_level = 1'b1;
            end else begin
               // falling edge: one microstep
               s.pin_level = 1'b0;
               s.steps_taken = s.steps_taken + 32'd1;
               if (s.steps_taken >= s.target_hold) begin
                  s.moving = 1'b0;
                  r.move_done = 1'b1;
               end else if (s.check_countdown != 16'd0) begin
                  s.check_countdown = s.check_countdown - 16'd1;
                  if (s.check_countdown == 16'd0) begin
                     // encoder check: signed wrapped delta, totals, floored error
                     s.check_countdown = c.check_interval;
                     diff = enc - s.last_sample;
                     delta = {{16{diff[15]}}, diff};
                     s.last_sample = enc;
                     moved = diff[15] ? -delta : delta;
                     if (moved > {16'd0, s.peak_hold}) s.peak_hold = moved[15:0];
                     s.commanded_total = s.commanded_total + {16'd0, c.check_interval};
                     s.travel_total = s.travel_total + delta;
                     travelled = s.travel_total[31] ? -s.travel_total : s.travel_total;
                     owed = s.commanded_total * {24'd0, c.owed_per_step};
                     delivered = travelled * {24'd0, c.credit_per_count};
                     s.error_now = (delivered >= owed) ? 32'd0 : owed - delivered;
                     if (s.error_now > s.error_worst) s.error_worst = s.error_now;
                     if (s.peak_hold != 16'd0 && s.error_now >= c.desync_limit) begin
                        s.moving = 1'b0;
                        s.stall_flag = 1'b1;
                     end
                  end
               end
            end
         end
      end
      r.step_level = s.pin_level;
      r.motor_enable = s.moving;
      r.stalled = s.stall_flag;
      r.desync_error = s.error_now;
      r.worst_desync = s.error_worst;
      r.peak_move = s.peak_hold;
      return r;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   // request driver, feeds the bus from the pending queue
   always @(negedge clock) begin : request_driver
      axis_req_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_accepted == req_sent) begin
         if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            nxt = pending_requests.pop_front();
            req_tdata <= {nxt.enc, nxt.target};
            req_tuser <= nxt.cmd;
            req_tvalid <= 1'b1;
            req_sent++;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   // monitor: register writes, accepted requests, accepted responses
   always @(posedge clock) begin : axis_monitor
      spg_result_type predicted;
      spg_result_type want;
      spg_result_type got;
      logic           was_moving;
      if (!reset) begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (spg_reg_type'(csr_paddr[4:2]))
               REG_TOGGLE_TICKS:     cfg_live.toggle_ticks = csr_pwdata[15:0];
               REG_CHECK_INTERVAL:   cfg_live.check_interval = csr_pwdata[15:0];
               REG_OWED_PER_STEP:    cfg_live.owed_per_step = csr_pwdata[7:0];
               REG_CREDIT_PER_COUNT: cfg_live.credit_per_count = csr_pwdata[7:0];
               REG_DESYNC_LIMIT:     cfg_live.desync_limit = csr_pwdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            was_moving = axis_now.moving;
            predicted = advance_axis(axis_now, cfg_live, req_tuser, req_tdata[31:0],
                                     req_tdata[47:32]);
            if (predicted.move_done) moves_done++;
            // stall flag is clear while moving, so this marks a fresh stall stop
            if (was_moving && predicted.stalled) stall_stops++;
            status_due.push_back(predicted);
            req_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = spg_result_type'(rsp_tdata[83:0]);
            if (status_due.size() == 0) begin
               $error("response with no request outstanding: 0x%0h", rsp_tdata);
               mismatches++;
            end else begin
               want = status_due.pop_front();
               check_field("step_level", want.step_level, got.step_level);
               check_field("motor_enable", want.motor_enable, got.motor_enable);
               check_field("move_done", want.move_done, got.move_done);
               check_field("stalled", want.stalled, got.stalled);
               check_field("desync_error", want.desync_error, got.desync_error);
               check_field("worst_desync", want.worst_desync, got.worst_desync);
               check_field("peak_move", want.peak_move, got.peak_move);
               check_field("zero fill", 32'd0, {28'd0, rsp_tdata[87:84]});
            end
         end
      end
   end

   task automatic csr_write(input spg_reg_type idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // sender holds off until every request has its response
   task automatic wait_drained();
      while (req_accepted != requests_queued || status_due.size() != 0) @(posedge clock);
   endtask

   task automatic queue_request(input logic cmd, input logic [31:0] target,
                                input logic [15:0] enc);
      axis_req_type it;
      it.cmd = cmd;
      it.target = target;
      it.enc = enc;
      void'(advance_axis(axis_plan, cfg_live, cmd, target, enc));
      pending_requests.push_back(it);
      requests_queued++;
   endtask

   task automatic apply_setting(input logic [15:0] toggle_ticks, input logic [15:0] interval,
                                input logic [7:0] per_step, input logic [7:0] per_count,
                                input logic [31:0] limit);
      wait_drained();
      csr_write(REG_TOGGLE_TICKS, {16'd0, toggle_ticks});
      csr_write(REG_CHECK_INTERVAL, {16'd0, interval});
      csr_write(REG_OWED_PER_STEP, {24'd0, per_step});
      csr_write(REG_CREDIT_PER_COUNT, {24'd0, per_count});
      csr_write(REG_DESYNC_LIMIT, limit);
      settings_used++;
   endtask

   // mostly well-formed moves: encoder follows the steps at a chosen gain,
   // with some slip and noise requests mixed in
   task automatic queue_moves(input int count);
      int          ratio;
      int          gain;
      int          jitter;
      logic [15:0] base;
      logic [31:0] target;
      ratio = (int'(cfg_live.owed_per_step) + int'(cfg_live.credit_per_count) - 1)
              / int'(cfg_live.credit_per_count);
      gain = ratio;
      base = 16'($urandom);
      repeat (count) begin
         jitter = ($urandom_range(3) == 0) ? int'($urandom_range(6)) - 3 : 0;
         if (!axis_plan.moving) begin
            if ($urandom_range(7) == 0) begin
               // tick while idle
               queue_request(CMD_TICK, $urandom, 16'($urandom));
            end else begin
               target = ($urandom_range(7) == 0) ? 32'd0 : 32'($urandom_range(1, 12));
               base = 16'($urandom);
               case ($urandom_range(4))
                  0:       gain = 0;
                  1:       gain = ratio - 1;
                  2:       gain = ratio;
                  default: gain = ratio + int'($urandom_range(1, 3));
               endcase
               if ($urandom_range(1) == 1) gain = -gain;
               queue_request(CMD_START, target, base);
            end
         end else if ($urandom_range(9) == 0) begin
            // noise: stray start or encoder glitch
            queue_request(1'($urandom_range(1)), $urandom, 16'($urandom));
         end else begin
            queue_request(CMD_TICK, $urandom,
                          16'(int'(base) + gain * int'(axis_plan.steps_taken) + jitter));
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: zero tick period, check every step, small limit
      apply_setting(16'd0, 16'd1, 8'd1, 8'd1, 32'd3);
      queue_request(CMD_TICK, 32'hFFFF_FFFF, 16'hFFFF);   // tick while idle
      queue_request(CMD_START, 32'd0, 16'h0000);          // zero target
      queue_request(CMD_TICK, 32'd0, 16'h0000);
      queue_request(CMD_TICK, 32'd0, 16'h0000);           // first microstep ends it
      queue_request(CMD_START, 32'hFFFF_FFFF, 16'hFFFF);  // largest target, baseline 0xffff
      queue_request(CMD_START, 32'd5, 16'h1234);          // start while moving acts as tick
      queue_request(CMD_TICK, 32'd0, 16'h7FFF);           // most negative delta
      queue_request(CMD_TICK, 32'd0, 16'h0000);
      queue_request(CMD_TICK, 32'd0, 16'hFFFE);           // most positive delta
      queue_request(CMD_TICK, 32'd0, 16'hFFFE);
      queue_request(CMD_TICK, 32'd0, 16'hFFFE);
      queue_request(CMD_TICK, 32'd0, 16'hFFFE);
      queue_request(CMD_TICK, 32'd0, 16'hFFFE);           // error reaches limit: stall stop
      queue_request(CMD_TICK, 32'hAAAA_AAAA, 16'h5555);   // idle after stall
      queue_request(CMD_START, 32'd2, 16'h0010);          // start clears the stall
      queue_request(CMD_TICK, 32'h5555_5555, 16'h0011);
      queue_request(CMD_TICK, 32'h5555_5555, 16'h0011);
      queue_request(CMD_TICK, 32'h5555_5555, 16'h0012);
      queue_request(CMD_TICK, 32'h5555_5555, 16'h0012);   // target reached, check skipped

      // random phases across register settings
      apply_setting(RST_TOGGLE_TICKS, RST_CHECK_INTERVAL, RST_OWED_PER_STEP,
                    RST_CREDIT_PER_COUNT, RST_DESYNC_LIMIT);
      queue_moves(280);

      apply_setting(16'd1, 16'd2, 8'd5, 8'd2, 32'd40);
      sender_idle_pct = 51;
      receiver_idle_pct = 25;
      queue_moves(250);

      apply_setting(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
      queue_moves(40);

      // stall monitoring off
      apply_setting(16'd0, 16'd0, 8'hFF, 8'd1, 32'd0);
      queue_moves(200);

      apply_setting(16'd2, 16'd1, 8'd1, 8'hFF, 32'hFFFF_FFFF);
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      queue_moves(180);

      apply_setting(16'd1, 16'd3, 8'hFF, 8'd128, 32'd0);
      queue_moves(200);

      wait_drained();
      repeat (10) @(posedge clock);
      $display("covered %0d requests over %0d register settings", req_accepted, settings_used);
      $display("moves completed: %0d, stall stops: %0d, mismatches: %0d",
               moves_done, stall_stops, mismatches);
      if (mismatches == 0 && status_due.size() == 0) begin
         $display("stepper_pulse_gen_stall_detect test passed");
      end else begin
         $display("stepper_pulse_gen_stall_detect test failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("stepper_pulse_gen_stall_detect test failed");
      $finish;
   end

endmodule
